@@ rtl/lps_pkg.sv @@
// Shared types and constants for the LED pattern sequencer.
`default_nettype none
package lps_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        PAT_OFF    = 3'd0,
        PAT_ON     = 3'd1,
        PAT_SLOW   = 3'd2,
        PAT_FAST   = 3'd3,
        PAT_PULSE  = 3'd4,
        PAT_DOUBLE = 3'd5,
        PAT_TRIPLE = 3'd6,
        PAT_SOS    = 3'd7
    } pattern_t;

    typedef enum logic {
        REG_PATTERN    = 1'b0,
        REG_BRIGHTNESS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        SOS_GAP  = 2'd0,
        SOS_DOT  = 2'd1,
        SOS_DASH = 2'd2,
        SOS_WORD = 2'd3
    } sos_code_t;

    localparam int SOS_LEN = 19;

    localparam sos_code_t SOS_TABLE [SOS_LEN] = '{
        SOS_DOT,  SOS_GAP, SOS_DOT,  SOS_GAP, SOS_DOT,  SOS_GAP,
        SOS_DASH, SOS_GAP, SOS_DASH, SOS_GAP, SOS_DASH, SOS_GAP,
        SOS_DOT,  SOS_GAP, SOS_DOT,  SOS_GAP, SOS_DOT,  SOS_GAP,
        SOS_WORD
    };

    // Pattern timing in milliseconds.
    localparam int SLOW_ON_MS     = 500;
    localparam int SLOW_CYCLE_MS  = 1000;
    localparam int FAST_ON_MS     = 100;
    localparam int FAST_CYCLE_MS  = 200;
    localparam int PULSE_HALF_MS  = 1000;
    localparam int PULSE_CYCLE_MS = 2000;
    localparam int FLASH_MS       = 100;
    localparam int DOUBLE_CYCLE_MS = 1200;
    localparam int TRIPLE_CYCLE_MS = 1400;
    localparam int SOS_SHORT_MS   = 200;
    localparam int SOS_DASH_MS    = 600;
    localparam int SOS_WORD_MS    = 1400;

    localparam logic [7:0] LEVEL_FULL = 8'd255;

    // floor(x / 1000) = (x * PULSE_RECIP) >> PULSE_SHIFT for x up to 255 * 999.
    localparam int PULSE_RECIP = 268436;
    localparam int PULSE_SHIFT = 28;
    localparam int PULSE_PROD_W = 37;

    typedef struct packed {
        logic restart;    // a different pattern was written
        logic load_held;  // the held duty takes a fixed value
        logic held_full;  // that value is the brightness setting, else zero
    } lps_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lps_cfg.sv @@
// APB register file for pattern select and brightness.
`default_nettype none
module lps_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lps_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lps_pkg::APB_DATA_W-1:0]   prdata,
    output lps_pkg::pattern_t                     pattern,
    output logic      [7:0]                       brightness,
    output lps_pkg::lps_ctrl_t                    ctrl
);
    import lps_pkg::*;

    pattern_t   pattern_reg;
    logic [7:0] brightness_reg;
    reg_index_t index;
    pattern_t   wr_pattern;
    logic       wr_en;

    assign index      = reg_index_t'(paddr[2]);
    assign wr_pattern = pattern_t'(pwdata[2:0]);
    assign wr_en      = psel && penable && pwrite;

    always_comb begin
        ctrl.restart   = wr_en && (index == REG_PATTERN) && (wr_pattern != pattern_reg);
        ctrl.load_held = ctrl.restart && ((wr_pattern == PAT_ON) || (wr_pattern == PAT_OFF));
        ctrl.held_full = (wr_pattern == PAT_ON);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg    <= PAT_OFF;
            brightness_reg <= LEVEL_FULL;
        end else if (wr_en) begin
            unique case (index)
                REG_PATTERN:    pattern_reg    <= wr_pattern;
                REG_BRIGHTNESS: brightness_reg <= pwdata[7:0];
                default:        pattern_reg    <= pattern_reg;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_PATTERN:    prdata = APB_DATA_W'(pattern_reg);
            REG_BRIGHTNESS: prdata = APB_DATA_W'(brightness_reg);
            default:        prdata = '0;
        endcase
    end

    assign pattern    = pattern_reg;
    assign brightness = brightness_reg;

endmodule
`default_nettype wire

@@ rtl/lps_timer.sv @@
// Time counter, SOS index and raw level decode for each tick item.
`default_nettype none
module lps_timer #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic [15:0]        elapsed_ms,
    input  wire lps_pkg::pattern_t  pattern,
    input  wire lps_pkg::lps_ctrl_t ctrl,
    output logic      [7:0]         raw,
    output logic                    hold
);
    import lps_pkg::*;

    localparam int TW = TIME_WIDTH;

    logic [TW-1:0]     elapsed_time_reg, elapsed_time_next;
    logic [4:0]        sos_index_reg, sos_index_next;
    logic [7:0]        raw_reg, raw_next;
    logic              hold_reg, hold_next;

    logic [TW-1:0]     t;
    logic [9:0]        ramp;
    logic [17:0]       ramp_x255;
    logic [PULSE_PROD_W-1:0] ramp_prod;
    logic [7:0]        ramp_level;
    sos_code_t         code;
    logic [TW-1:0]     code_dur;
    logic              code_lit;

    assign t = elapsed_time_reg + TW'(elapsed_ms);

    // Both halves of the triangle share one divide-by-1000.
    always_comb begin
        if (t < TW'(PULSE_HALF_MS)) begin
            ramp = t[9:0];
        end else begin
            ramp = 10'(t - TW'(PULSE_HALF_MS));
        end
        ramp_x255  = {ramp, 8'b0} - {8'b0, ramp};
        ramp_prod  = PULSE_PROD_W'(ramp_x255) * PULSE_PROD_W'(PULSE_RECIP);
        ramp_level = ramp_prod[PULSE_SHIFT +: 8];
    end

    always_comb begin
        if (sos_index_reg < 5'(SOS_LEN)) begin
            code = SOS_TABLE[sos_index_reg];
        end else begin
            code = SOS_GAP;
        end
        unique case (code)
            SOS_DOT:  begin code_dur = TW'(SOS_SHORT_MS); code_lit = 1'b1; end
            SOS_DASH: begin code_dur = TW'(SOS_DASH_MS);  code_lit = 1'b1; end
            SOS_WORD: begin code_dur = TW'(SOS_WORD_MS);  code_lit = 1'b0; end
            default:  begin code_dur = TW'(SOS_SHORT_MS); code_lit = 1'b0; end
        endcase
    end

    always_comb begin
        elapsed_time_next = t;
        sos_index_next    = sos_index_reg;
        raw_next          = '0;
        hold_next         = 1'b0;
        unique case (pattern)
            PAT_OFF: raw_next = '0;
            PAT_ON:  raw_next = LEVEL_FULL;
            PAT_SLOW: begin
                if (t < TW'(SLOW_ON_MS)) begin
                    raw_next = LEVEL_FULL;
                end else if (t >= TW'(SLOW_CYCLE_MS)) begin
                    elapsed_time_next = '0;
                    hold_next         = 1'b1;
                end
            end
            PAT_FAST: begin
                if (t < TW'(FAST_ON_MS)) begin
                    raw_next = LEVEL_FULL;
                end else if (t >= TW'(FAST_CYCLE_MS)) begin
                    elapsed_time_next = '0;
                    hold_next         = 1'b1;
                end
            end
            PAT_PULSE: begin
                if (t < TW'(PULSE_HALF_MS)) begin
                    raw_next = ramp_level;
                end else if (t < TW'(PULSE_CYCLE_MS)) begin
                    raw_next = LEVEL_FULL - ramp_level;
                end else begin
                    elapsed_time_next = '0;
                end
            end
            PAT_DOUBLE: begin
                if (t >= TW'(DOUBLE_CYCLE_MS)) begin
                    elapsed_time_next = '0;
                    hold_next         = 1'b1;
                end else if (t < TW'(FLASH_MS) ||
                             (t >= TW'(2 * FLASH_MS) && t < TW'(3 * FLASH_MS))) begin
                    raw_next = LEVEL_FULL;
                end
            end
            PAT_TRIPLE: begin
                if (t >= TW'(TRIPLE_CYCLE_MS)) begin
                    elapsed_time_next = '0;
                    hold_next         = 1'b1;
                end else if (t < TW'(FLASH_MS) ||
                             (t >= TW'(2 * FLASH_MS) && t < TW'(3 * FLASH_MS)) ||
                             (t >= TW'(4 * FLASH_MS) && t < TW'(5 * FLASH_MS))) begin
                    raw_next = LEVEL_FULL;
                end
            end
            PAT_SOS: begin
                raw_next = code_lit ? LEVEL_FULL : 8'd0;
                if (t >= code_dur) begin
                    elapsed_time_next = '0;
                    sos_index_next    = (sos_index_reg >= 5'(SOS_LEN - 1)) ? 5'd0
                                                                           : sos_index_reg + 5'd1;
                end
            end
            default: raw_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_time_reg <= '0;
            sos_index_reg    <= '0;
        end else if (ctrl.restart) begin
            elapsed_time_reg <= '0;
            sos_index_reg    <= '0;
        end else if (load) begin
            elapsed_time_reg <= elapsed_time_next;
            sos_index_reg    <= sos_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            raw_reg  <= raw_next;
            hold_reg <= hold_next;
        end
    end

    assign raw  = raw_reg;
    assign hold = hold_reg;

endmodule
`default_nettype wire

@@ rtl/lps_scale.sv @@
// Brightness scaling and the held duty that forms the result register.
`default_nettype none
module lps_scale (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic [7:0]         raw,
    input  wire logic               hold,
    input  wire logic [7:0]         brightness,
    input  wire lps_pkg::lps_ctrl_t ctrl,
    output logic      [7:0]         duty
);
    import lps_pkg::*;

    logic [7:0]  held_duty_reg, held_duty_next;
    logic [15:0] product;
    logic [16:0] rounded;

    // Exact floor of the raw-times-brightness product divided by 255.
    always_comb begin
        product = 16'(raw) * 16'(brightness);
        rounded = 17'(product) + 17'(product[15:8]) + 17'd1;
        held_duty_next = hold ? held_duty_reg : rounded[15:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_duty_reg <= '0;
        end else if (ctrl.load_held) begin
            held_duty_reg <= ctrl.held_full ? brightness : 8'd0;
        end else if (load) begin
            held_duty_reg <= held_duty_next;
        end
    end

    assign duty = held_duty_reg;

endmodule
`default_nettype wire

@@ rtl/led_pattern_sequencer.sv @@
// LED pattern sequencer top level: handshake pipeline and submodule wiring.
//
// Each item on the s_ channel is a tick carrying the milliseconds since the
// previous tick; for every item exactly one duty result leaves on the m_
// channel, in order. Pattern and brightness are set over the APB port, which
// must be written only while no item is in flight; the block does not enforce it.
//
// The pipeline has three registered stages: the input register, the raw
// level register (time counter and SOS index update here) and the held
// duty register that carries the result. An accepted item moves through
// them in that order, and one item per cycle is sustained while the receiver
// does not stall; the time counter update in the middle stage sets that rate.
//
// Reset selects pattern off, brightness full, and clears the time counter,
// SOS index, held duty and all valid flags. When the receiver stalls, each
// stage keeps its item and up to three items are absorbed before s_ready drops.
`default_nettype none
module led_pattern_sequencer #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [15:0]                      s_elapsed_ms,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [7:0]                       m_duty,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lps_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import lps_pkg::*;

    logic        in_valid_reg;
    logic [15:0] in_elapsed_reg;
    logic        mid_valid_reg;
    logic        out_valid_reg;
    logic        out_ready, mid_ready;
    logic        mid_adv, out_adv;

    pattern_t    pattern;
    logic [7:0]  brightness;
    lps_ctrl_t   ctrl;
    logic [7:0]  raw;
    logic        hold;

    assign out_ready = !out_valid_reg || m_ready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign s_ready   = !in_valid_reg || mid_ready;
    assign mid_adv   = in_valid_reg && mid_ready;
    assign out_adv   = mid_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_ready) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_elapsed_reg <= s_elapsed_ms;
        end
    end

    lps_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pattern    (pattern),
        .brightness (brightness),
        .ctrl       (ctrl)
    );

    lps_timer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (mid_adv),
        .elapsed_ms (in_elapsed_reg),
        .pattern    (pattern),
        .ctrl       (ctrl),
        .raw        (raw),
        .hold       (hold)
    );

    lps_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (out_adv),
        .raw        (raw),
        .hold       (hold),
        .brightness (brightness),
        .ctrl       (ctrl),
        .duty       (m_duty)
    );

    assign m_valid = out_valid_reg;
    assign pready  = 1'b1;

    a_mid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_adv |=> mid_valid_reg)
        else $error("item leaving the input register did not reach the middle stage");

    a_out_from_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(mid_valid_reg))
        else $error("result appeared without an item in the middle stage");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !mid_ready) |=> (in_valid_reg && $stable(in_elapsed_reg)))
        else $error("input register lost its item while the pipeline was stalled");

endmodule
`default_nettype wire
